// ===== src/sorted_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shorthand for clocked implication checks, gated off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, defaults, request codes and status codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // default sizing
  localparam int DEPTH_DEF     = 256;
  localparam int FREQ_BITS_DEF = 32;

  // fixed field widths
  localparam int SYM_W      = 8;
  localparam int IN_FREQ_W  = 32;
  localparam int OUT_FREQ_W = 32;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 9;

  // default ram entry width: symbol plus frequency
  localparam int ENTRY_W_DEF = SYM_W + FREQ_BITS_DEF;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ONE   = 2'd3;

endpackage

`default_nettype wire

// ===== src/spq_ram.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue RAM
// Simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ram
  import spq_pkg::*;
#(
  parameter int WIDTH = ENTRY_W_DEF,
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue of (symbol, frequency) entries, lowest frequency first.
// Requests enter on the s_axis channel (tuser = request kind) and results leave
// on the m_axis channel, tlast marking the final result of a request.
// Insert: one result. Remove: two results (two lowest entries), or one result
// when one entry or none is held. Query: one result with count and empty flag.
// Entries live in one RAM used as a circular buffer, so a remove only moves
// the head pointer. An insert scans back from the tail, one entry per cycle,
// moving each entry that sorts after the new one up by one slot.
// States from acceptance to first result in the output register:
//   query, full insert, remove on empty, insert into empty store: S_EMIT
//   insert: S_SCAN once per entry read, S_INS_WR if the head moves, S_EMIT
//   remove: S_REM_A, S_REM_B when two entries are held, S_EMIT once per result
// The rate is set by the single read port of the RAM: one entry per cycle.
// One request is worked on at a time; the next is accepted once the last result
// of the current one sits in the output register, even if not yet taken.
// Reset empties the queue at once; no clearing pass is needed.
// A stalled receiver holds the output register and S_EMIT, blocking requests.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// Sorted priority queue
// Ascending-frequency queue in a circular RAM with insertion-scan control
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // entry_symbol[7:0], entry_frequency[39:8]
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  // result channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // out_symbol[7:0], out_frequency[39:8],
                                          // status[41:40], entry_count[50:42],
                                          // queue_empty[51], zero[55:52]
  output logic             m_axis_tlast   // last
);

  `include "sorted_priority_queue_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = SYM_W + FREQ_BITS;
  localparam int XW = (FREQ_BITS > OUT_FREQ_W) ? FREQ_BITS : OUT_FREQ_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_INS_WR = 6'b000100,
    S_REM_A  = 6'b001000,
    S_REM_B  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  // registers
  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         idx, idx_next;
  logic [SYM_W-1:0]      req_sym, req_sym_next;
  logic [FREQ_BITS-1:0]  req_freq, req_freq_next;
  logic [SYM_W-1:0]      a_sym, a_sym_next, b_sym, b_sym_next;
  logic [FREQ_BITS-1:0]  a_freq, a_freq_next, b_freq, b_freq_next;
  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic                  two_res, two_res_next;
  logic                  emit_idx, emit_idx_next;
  logic                  o_valid, o_valid_next;
  logic [SYM_W-1:0]      o_sym, o_sym_next;
  logic [OUT_FREQ_W-1:0] o_freq, o_freq_next;
  logic [STATUS_W-1:0]   o_status, o_status_next;
  logic [COUNT_W-1:0]    o_count, o_count_next;
  logic                  o_empty, o_empty_next;
  logic                  o_last, o_last_next;

  // ram ports
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [EW-1:0]         wr_data, rd_data;

  // unpacked request and ram read fields
  logic [REQ_W-1:0]      in_req;
  logic [SYM_W-1:0]      in_sym;
  logic [XW-1:0]         in_ext;
  logic [FREQ_BITS-1:0]  in_freq;
  logic [SYM_W-1:0]      rd_sym;
  logic [FREQ_BITS-1:0]  rd_freq;
  logic [FREQ_BITS-1:0]  sel_freq;
  logic [XW-1:0]         sel_ext;
  logic                  out_free;
  logic                  shift;

  assign in_req  = s_axis_tuser;
  assign in_sym  = s_axis_tdata[SYM_W-1:0];
  assign in_ext  = XW'(s_axis_tdata[SYM_W +: IN_FREQ_W]);
  assign in_freq = in_ext[FREQ_BITS-1:0];
  assign rd_sym  = rd_data[EW-1:FREQ_BITS];
  assign rd_freq = rd_data[FREQ_BITS-1:0];

  // logical queue position to physical ram address
  function automatic logic [AW-1:0] phys(input logic [CW-1:0] lidx);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(lidx);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !o_valid || m_axis_tready;
  assign sel_freq = emit_idx ? b_freq : a_freq;
  assign sel_ext  = XW'(sel_freq);

  // entry at idx sorts after the new one; the head only yields to a smaller key
  assign shift = (idx == '0) ? (rd_freq > req_freq) : (rd_freq >= req_freq);

  // control and datapath
  always_comb begin
    state_next      = state;
    count_next      = count;
    head_next       = head;
    idx_next        = idx;
    req_sym_next    = req_sym;
    req_freq_next   = req_freq;
    a_sym_next      = a_sym;
    a_freq_next     = a_freq;
    b_sym_next      = b_sym;
    b_freq_next     = b_freq;
    res_status_next = res_status;
    two_res_next    = two_res;
    emit_idx_next   = emit_idx;
    o_valid_next    = o_valid && !m_axis_tready;
    o_sym_next      = o_sym;
    o_freq_next     = o_freq;
    o_status_next   = o_status;
    o_count_next    = o_count;
    o_empty_next    = o_empty;
    o_last_next     = o_last;
    wr_en           = 1'b0;
    wr_addr         = head;
    wr_data         = {req_sym, req_freq};
    rd_en           = 1'b0;
    rd_addr         = head;

    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_sym_next    = in_sym;
          req_freq_next   = in_freq;
          a_sym_next      = '0;
          a_freq_next     = '0;
          two_res_next    = 1'b0;
          emit_idx_next   = 1'b0;
          res_status_next = STATUS_OK;
          state_next      = S_EMIT;
          case (in_req)
            REQ_INSERT: begin
              if (count == DEPTH_C) begin
                res_status_next = STATUS_FULL;
              end else if (count == '0) begin
                wr_en      = 1'b1;
                wr_addr    = head;
                wr_data    = {in_sym, in_freq};
                count_next = count + 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = phys(count - 1'b1);
                idx_next   = count - 1'b1;
                state_next = S_SCAN;
              end
            end
            REQ_REMOVE: begin
              if (count == '0) begin
                res_status_next = STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                state_next = S_REM_A;
              end
            end
            default: begin
              res_status_next = STATUS_OK;
            end
          endcase
        end
      end

      // walk back from the tail, moving entries that sort after the new one up one slot
      S_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = phys(idx + 1'b1);
        if (shift) begin
          wr_data = rd_data;
          if (idx == '0) begin
            state_next = S_INS_WR;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = phys(idx - 1'b1);
            idx_next = idx - 1'b1;
          end
        end else begin
          count_next = count + 1'b1;
          state_next = S_EMIT;
        end
      end

      // new entry becomes the head
      S_INS_WR: begin
        wr_en      = 1'b1;
        wr_addr    = head;
        count_next = count + 1'b1;
        state_next = S_EMIT;
      end

      S_REM_A: begin
        a_sym_next  = rd_sym;
        a_freq_next = rd_freq;
        if (count == CW'(1)) begin
          count_next      = '0;
          head_next       = phys(CW'(1));
          res_status_next = STATUS_ONE;
          state_next      = S_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = phys(CW'(1));
          state_next = S_REM_B;
        end
      end

      S_REM_B: begin
        b_sym_next   = rd_sym;
        b_freq_next  = rd_freq;
        count_next   = count - CW'(2);
        head_next    = phys(CW'(2));
        two_res_next = 1'b1;
        state_next   = S_EMIT;
      end

      // hand results to the output register as it frees up
      S_EMIT: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_sym_next    = emit_idx ? b_sym : a_sym;
          o_freq_next   = sel_ext[OUT_FREQ_W-1:0];
          o_status_next = res_status;
          o_count_next  = COUNT_W'(count);
          o_empty_next  = (count == '0);
          o_last_next   = !two_res || emit_idx;
          if (two_res && !emit_idx) begin
            emit_idx_next = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      head    <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      head    <= head_next;
      o_valid <= o_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    req_sym    <= req_sym_next;
    req_freq   <= req_freq_next;
    a_sym      <= a_sym_next;
    a_freq     <= a_freq_next;
    b_sym      <= b_sym_next;
    b_freq     <= b_freq_next;
    res_status <= res_status_next;
    two_res    <= two_res_next;
    emit_idx   <= emit_idx_next;
    o_sym      <= o_sym_next;
    o_freq     <= o_freq_next;
    o_status   <= o_status_next;
    o_count    <= o_count_next;
    o_empty    <= o_empty_next;
    o_last     <= o_last_next;
  end

  // ports
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {4'b0, o_empty, o_count, o_status, o_freq, o_sym};

  // checks
  `SPQ_ASSERT_IMPL(count_in_range, 1'b1, count <= DEPTH_C, "entry count above depth")
  `SPQ_ASSERT_NEXT(count_step, 1'b1, (count == $past(count)) || (count == $past(count) + 1) || (count + 1 == $past(count)) || (count + 2 == $past(count)), "entry count jumped")
  `SPQ_ASSERT_IMPL(pair_ordered, (state == S_EMIT) && two_res, a_freq <= b_freq, "removed pair out of order")
  `SPQ_ASSERT_IMPL(non_last_is_ok, m_axis_tvalid && !m_axis_tlast, o_status == STATUS_OK, "first of pair has bad status")

endmodule

`default_nettype wire
